FILE: rtl/ssr_pkg.sv
// shared types and constants for the settings sync requester
package ssr_pkg;

    // command codes carried in the input beat's tuser
    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_POLL = 2'd1,
        CMD_ACK  = 2'd2
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] CFG_RETRY_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_QUERY_PERIOD   = 2'd1;
    localparam int unsigned CFG_INDEX_W = 2;

    // acknowledgement status codes
    localparam logic [1:0] STATUS_BUSY = 2'd2;

    // setting selectors for a set beat
    localparam logic [1:0] FIELD_INTENSITY = 2'd1;
    localparam logic [1:0] FIELD_LEVEL     = 2'd2;

    // reset values and limits
    localparam logic [31:0] RETRY_INTERVAL_RESET = 32'd250;
    localparam logic [31:0] QUERY_PERIOD_RESET   = 32'd1000;
    localparam logic [7:0]  INTENSITY_MAX        = 8'd100;
    localparam logic [7:0]  LEVEL_MIN            = 8'd1;
    localparam logic [7:0]  LEVEL_MAX            = 8'd3;
    localparam logic [7:0]  REPORTED_INTENSITY_RESET = 8'd63;
    localparam logic [7:0]  REPORTED_LEVEL_RESET     = 8'd2;

    // bus widths
    localparam int unsigned S_TDATA_W = 280;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 176;
    localparam int unsigned M_TUSER_W = 1;

    // one input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now;
        logic        link_live;
        logic [47:0] tgt_mac;
        logic [31:0] tgt_session;
        logic [47:0] peer_mac;
        logic [31:0] msg_session;
        logic [31:0] msg_client;
        logic [31:0] msg_sequence;
        logic [1:0]  mask_or_field;
        logic [15:0] payload;
        logic [1:0]  ack_status;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic        send;
        logic [47:0] tx_mac;
        logic [31:0] tx_session;
        logic [31:0] tx_client;
        logic [31:0] tx_sequence;
        logic [1:0]  tx_mask;
        logic [6:0]  tx_intensity;
        logic [1:0]  tx_level;
        logic [7:0]  rpt_intensity;
        logic [7:0]  rpt_level;
        logic        accepted;
    } out_item_t;

    // configuration write strobe toward the core
    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
    } cfg_wr_t;

endpackage

FILE: rtl/ssr_core.sv
// sync state and per-item update logic of the settings sync requester
module ssr_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssr_pkg::cfg_wr_t  cfg_wr,
    input  logic              fire,
    input  ssr_pkg::in_item_t item,
    output ssr_pkg::out_item_t result
);
    import ssr_pkg::*;

    typedef struct packed {
        logic [7:0]  reported_intensity;
        logic [7:0]  reported_level;
        logic [6:0]  want_intensity;
        logic [1:0]  want_level;
        logic [1:0]  dirty;
        logic [31:0] rev0;
        logic [31:0] rev1;
        logic [31:0] snap0;
        logic [31:0] snap1;
        logic [31:0] txn_session;
        logic [31:0] txn_client;
        logic [31:0] txn_sequence;
        logic [1:0]  txn_mask;
        logic [6:0]  txn_intensity;
        logic [1:0]  txn_level;
        logic [47:0] known_mac;
        logic [31:0] known_session;
        logic [31:0] nonce_word;
        logic [31:0] sequence_counter;
        logic [31:0] last_attempt;
        logic [31:0] last_sync;
        logic        pending;
        logic        synced;
    } state_t;

    state_t      st_reg, st_next;
    state_t      st_init;
    logic [31:0] retry_interval_reg;
    logic [31:0] query_period_reg;

    logic [7:0]  set_value;
    logic        new_target;
    logic        eff_synced, eff_pending;
    logic        open_txn;
    logic [31:0] seq_inc;
    logic [31:0] nonce_use;
    logic        ack_match;
    logic        send;
    logic        accepted;

    // reset image of the sync state
    always_comb begin
        st_init                    = '0;
        st_init.reported_intensity = REPORTED_INTENSITY_RESET;
        st_init.reported_level     = REPORTED_LEVEL_RESET;
    end

    // config registers and sync state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_interval_reg <= RETRY_INTERVAL_RESET;
            query_period_reg   <= QUERY_PERIOD_RESET;
            st_reg             <= st_init;
        end else begin
            if (cfg_wr.we) begin
                case (cfg_wr.index)
                    CFG_RETRY_INTERVAL: retry_interval_reg <= cfg_wr.data;
                    CFG_QUERY_PERIOD:   query_period_reg   <= cfg_wr.data;
                    default: ;
                endcase
            end
            if (fire) begin
                st_reg <= st_next;
            end
        end
    end

    // shared helper terms
    assign set_value  = item.payload[7:0];
    assign new_target = (st_reg.known_session != item.tgt_session) ||
                        (st_reg.known_mac != item.tgt_mac);
    assign eff_synced  = st_reg.synced  && !new_target;
    assign eff_pending = st_reg.pending && !new_target;
    assign seq_inc   = (st_reg.sequence_counter == 32'hFFFF_FFFF) ? 32'd1
                     : st_reg.sequence_counter + 32'd1;
    assign nonce_use = (st_reg.nonce_word != 32'd0) ? st_reg.nonce_word
                     : ((item.msg_client != 32'd0) ? item.msg_client : 32'd1);
    assign open_txn  = !eff_pending &&
                       (!eff_synced || (st_reg.dirty != 2'b00) ||
                        ((item.now - st_reg.last_sync) >= query_period_reg));
    assign ack_match = item.link_live && (item.peer_mac == item.tgt_mac) &&
                       st_reg.pending && (item.tgt_session == st_reg.known_session) &&
                       (item.msg_session == st_reg.txn_session) &&
                       (item.peer_mac == st_reg.known_mac) &&
                       (item.msg_client == st_reg.txn_client) &&
                       (item.msg_sequence == st_reg.txn_sequence) &&
                       (item.mask_or_field == st_reg.txn_mask);

    // next state per command
    always_comb begin
        st_next  = st_reg;
        send     = 1'b0;
        accepted = 1'b0;
        case (item.cmd)
            CMD_SET: begin
                if (item.mask_or_field == FIELD_INTENSITY && set_value <= INTENSITY_MAX) begin
                    st_next.want_intensity = set_value[6:0];
                    st_next.rev0  = st_reg.rev0 + 32'd1;
                    st_next.dirty = st_reg.dirty | 2'b01;
                    accepted = 1'b1;
                end else if (item.mask_or_field == FIELD_LEVEL &&
                             set_value >= LEVEL_MIN && set_value <= LEVEL_MAX) begin
                    st_next.want_level = set_value[1:0];
                    st_next.rev1  = st_reg.rev1 + 32'd1;
                    st_next.dirty = st_reg.dirty | 2'b10;
                    accepted = 1'b1;
                end
            end
            CMD_POLL: begin
                if (!item.link_live) begin
                    st_next.synced  = 1'b0;
                    st_next.pending = 1'b0;
                end else begin
                    st_next.known_mac     = item.tgt_mac;
                    st_next.known_session = item.tgt_session;
                    st_next.synced        = eff_synced;
                    st_next.pending       = eff_pending;
                    if (eff_pending) begin
                        send = (item.now - st_reg.last_attempt) >= retry_interval_reg;
                    end else if (open_txn) begin
                        st_next.nonce_word       = nonce_use;
                        st_next.sequence_counter = seq_inc;
                        st_next.txn_session      = item.tgt_session;
                        st_next.txn_client       = nonce_use;
                        st_next.txn_sequence     = seq_inc;
                        st_next.txn_mask         = eff_synced ? st_reg.dirty : 2'b00;
                        st_next.txn_intensity    = (eff_synced && st_reg.dirty[0])
                                                 ? st_reg.want_intensity : 7'd0;
                        st_next.txn_level        = (eff_synced && st_reg.dirty[1])
                                                 ? st_reg.want_level : 2'd0;
                        st_next.snap0   = st_reg.rev0;
                        st_next.snap1   = st_reg.rev1;
                        st_next.pending = 1'b1;
                        send = 1'b1;
                    end
                    if (send) begin
                        st_next.last_attempt = item.now;
                    end
                end
            end
            CMD_ACK: begin
                if (ack_match) begin
                    accepted = 1'b1;
                    st_next.reported_intensity = item.payload[7:0];
                    st_next.reported_level     = item.payload[15:8];
                    if (item.ack_status != STATUS_BUSY) begin
                        if (st_reg.txn_mask[0] && st_reg.rev0 == st_reg.snap0) begin
                            st_next.dirty[0] = 1'b0;
                        end
                        if (st_reg.txn_mask[1] && st_reg.rev1 == st_reg.snap1) begin
                            st_next.dirty[1] = 1'b0;
                        end
                        st_next.pending   = 1'b0;
                        st_next.synced    = 1'b1;
                        st_next.last_sync = item.now;
                    end
                end
            end
            default: ;
        endcase
    end

    // result fields, packet fields zeroed without a send
    always_comb begin
        result               = '0;
        result.send          = send;
        result.rpt_intensity = st_next.reported_intensity;
        result.rpt_level     = st_next.reported_level;
        result.accepted      = accepted;
        if (send) begin
            result.tx_mac       = st_next.known_mac;
            result.tx_session   = st_next.txn_session;
            result.tx_client    = st_next.txn_client;
            result.tx_sequence  = st_next.txn_sequence;
            result.tx_mask      = st_next.txn_mask;
            result.tx_intensity = st_next.txn_intensity;
            result.tx_level     = st_next.txn_level;
        end
    end

endmodule

FILE: rtl/ssr_skid.sv
// output register with skid stage for result beats
module ssr_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ssr_pkg::out_item_t push_data,
    output logic               push_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output ssr_pkg::out_item_t m_data
);
    import ssr_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_data_reg, main_data_next;
    out_item_t skid_data_reg, skid_data_next;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    // fill main first, spill into skid when main is stalled
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (push) begin
            if (!main_valid_reg || m_ready) begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (main_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end
    end

    assign push_ready = !skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_data     = main_data_reg;

endmodule

FILE: rtl/settings_sync_requester.sv
// top level of the settings sync requester
//
// channel   dir  handshake                fields
// s_        in   s_tvalid / s_tready      tuser: cmd; tdata: item fields
// m_        out  m_tvalid / m_tready      tuser: send; tdata: packet and status
// cfg_      in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one result beat per input beat, one beat a cycle sustained while m_ does not stall;
// from input beat to result beat an item passes the input register, then the output register
// the sync state updates in the cycle an item leaves the input register
// synchronous active-low reset restores the sync state, the valid flags and the config registers
// a stall on m_ fills the skid stage, then holds the input register and s_tready
// cfg_ready is always high
module settings_sync_requester (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // from bit 0: now, link_live, tgt_mac, tgt_session, peer_mac,
    // msg_session, msg_client, msg_sequence, mask_or_field, payload, ack_status
    input  logic [ssr_pkg::S_TDATA_W-1:0]   s_tdata,
    // from bit 0: cmd
    input  logic [ssr_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // from bit 0: tx_mac, tx_session, tx_client, tx_sequence, tx_mask,
    // tx_intensity, tx_level, rpt_intensity, rpt_level, accepted
    output logic [ssr_pkg::M_TDATA_W-1:0]   m_tdata,
    // from bit 0: send
    output logic [ssr_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);
    import ssr_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    in_item_t  in_unpacked;
    logic      fire;
    logic      skid_ready;
    out_item_t core_result;
    out_item_t out_item;
    cfg_wr_t   cfg_wr;

    // unpack the input beat
    always_comb begin
        in_unpacked.cmd            = s_tuser[1:0];
        in_unpacked.now            = s_tdata[31:0];
        in_unpacked.link_live      = s_tdata[32];
        in_unpacked.tgt_mac        = s_tdata[80:33];
        in_unpacked.tgt_session    = s_tdata[112:81];
        in_unpacked.peer_mac       = s_tdata[160:113];
        in_unpacked.msg_session    = s_tdata[192:161];
        in_unpacked.msg_client     = s_tdata[224:193];
        in_unpacked.msg_sequence   = s_tdata[256:225];
        in_unpacked.mask_or_field  = s_tdata[258:257];
        in_unpacked.payload        = s_tdata[274:259];
        in_unpacked.ack_status     = s_tdata[276:275];
    end

    assign fire     = in_valid_reg && skid_ready;
    assign s_tready = !in_valid_reg || fire;

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_unpacked;
        end
    end

    // config write strobe
    assign cfg_ready    = 1'b1;
    assign cfg_wr.we    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    ssr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .fire    (fire),
        .item    (in_item_reg),
        .result  (core_result)
    );

    ssr_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fire),
        .push_data  (core_result),
        .push_ready (skid_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (out_item)
    );

    // pack the result beat
    assign m_tuser = out_item.send;
    assign m_tdata = {4'd0,
                      out_item.accepted,
                      out_item.rpt_level,
                      out_item.rpt_intensity,
                      out_item.tx_level,
                      out_item.tx_intensity,
                      out_item.tx_mask,
                      out_item.tx_sequence,
                      out_item.tx_client,
                      out_item.tx_session,
                      out_item.tx_mac};

endmodule

FILE: sim/settings_sync_requester_test.sv
// testbench for the settings sync requester: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module settings_sync_requester_test;
    import ssr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 120;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_RESERVED       = 2'd3;
    localparam logic [1:0] FIELD_NONE         = 2'd0;
    localparam logic [1:0] FIELD_BOTH         = 2'd3;
    localparam logic [1:0] STATUS_APPLIED     = 2'd0;
    localparam logic [1:0] STATUS_NOT_APPLIED = 2'd1;
    localparam logic [1:0] STATUS_RESERVED    = 2'd3;

    // predicted sync state together with the timing registers
    typedef struct packed {
        logic [31:0]      retry_ticks;
        logic [31:0]      query_ticks;
        logic [7:0]       rep_int;
        logic [7:0]       rep_lvl;
        logic [6:0]       want_int;
        logic [1:0]       want_lvl;
        logic [1:0]       dirty;
        logic [1:0][31:0] rev;
        logic [1:0][31:0] snap;
        logic [31:0]      pk_session;
        logic [31:0]      pk_client;
        logic [31:0]      pk_seq;
        logic [1:0]       pk_mask;
        logic [6:0]       pk_int;
        logic [1:0]       pk_lvl;
        logic [47:0]      peer_addr;
        logic [31:0]      peer_sess;
        logic [31:0]      nonce;
        logic [31:0]      seq_ctr;
        logic [31:0]      last_try;
        logic [31:0]      last_sync;
        logic             pending;
        logic             synced;
    } sync_state_t;

    typedef struct packed {
        sync_state_t st;
        out_item_t   r;
    } sync_step_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;

    in_item_t    beats_to_send [$];
    out_item_t   due_results [$];
    sync_state_t model_st;
    sync_state_t plan_st;
    sync_step_t  model_step;
    in_item_t    s_cur;
    out_item_t   seen_r;
    out_item_t   due_r;
    logic [3:0]  m_pad;

    logic [47:0] mac_pool [3];
    logic [31:0] sess_pool [3];
    logic [47:0] cur_mac;
    logic [31:0] cur_sess;
    logic [31:0] tick;

    bit          s_taken      = 1'b0;
    bit          tx_pace      = 1'b0;
    bit          rx_pace      = 1'b0;
    int unsigned tx_wait      = 0;
    int unsigned rx_wait      = 0;
    int unsigned hold_left    = 0;
    int unsigned holds_done   = 0;
    int unsigned results_seen = 0;
    int unsigned cycles       = 0;
    int          errors       = 0;

    always #2 aclk = ~aclk;

    settings_sync_requester u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic sync_state_t reset_state();
        sync_state_t s;
        s = '0;
        s.retry_ticks = RETRY_INTERVAL_RESET;
        s.query_ticks = QUERY_PERIOD_RESET;
        s.rep_int     = REPORTED_INTENSITY_RESET;
        s.rep_lvl     = REPORTED_LEVEL_RESET;
        return s;
    endfunction

    // next state and result beat for one input beat
    function automatic sync_step_t sync_step(sync_state_t st, in_item_t it);
        sync_step_t o;
        logic       snd;
        logic       acc;
        snd = 1'b0;
        acc = 1'b0;
        case (it.cmd)
            CMD_SET: begin
                if (it.mask_or_field == FIELD_INTENSITY && it.payload[7:0] <= INTENSITY_MAX) begin
                    st.want_int = it.payload[6:0];
                    st.rev[0]   = st.rev[0] + 32'd1;
                    st.dirty[0] = 1'b1;
                    acc = 1'b1;
                end else if (it.mask_or_field == FIELD_LEVEL && it.payload[7:0] >= LEVEL_MIN &&
                             it.payload[7:0] <= LEVEL_MAX) begin
                    st.want_lvl = it.payload[1:0];
                    st.rev[1]   = st.rev[1] + 32'd1;
                    st.dirty[1] = 1'b1;
                    acc = 1'b1;
                end
            end
            CMD_POLL: begin
                if (!it.link_live) begin
                    st.synced  = 1'b0;
                    st.pending = 1'b0;
                end else begin
                    // a different target drops sync
                    if (st.peer_sess != it.tgt_session || st.peer_addr != it.tgt_mac) begin
                        st.peer_addr = it.tgt_mac;
                        st.peer_sess = it.tgt_session;
                        st.synced    = 1'b0;
                        st.pending   = 1'b0;
                    end
                    if (st.pending) begin
                        snd = (it.now - st.last_try) >= st.retry_ticks;
                    end else if (!st.synced || st.dirty != 2'b00 ||
                                 (it.now - st.last_sync) >= st.query_ticks) begin
                        if (st.nonce == 32'd0)
                            st.nonce = (it.msg_client != 32'd0) ? it.msg_client : 32'd1;
                        st.seq_ctr = st.seq_ctr + 32'd1;
                        if (st.seq_ctr == 32'd0)
                            st.seq_ctr = 32'd1;
                        st.pk_session = it.tgt_session;
                        st.pk_client  = st.nonce;
                        st.pk_seq     = st.seq_ctr;
                        st.pk_mask    = st.synced ? st.dirty : 2'b00;
                        st.pk_int     = st.pk_mask[0] ? st.want_int : 7'd0;
                        st.pk_lvl     = st.pk_mask[1] ? st.want_lvl : 2'd0;
                        st.snap       = st.rev;
                        st.pending    = 1'b1;
                        snd = 1'b1;
                    end
                    if (snd)
                        st.last_try = it.now;
                end
            end
            CMD_ACK: begin
                if (it.link_live && it.peer_mac == it.tgt_mac && st.pending &&
                    it.tgt_session == st.peer_sess && it.msg_session == st.pk_session &&
                    it.peer_mac == st.peer_addr && it.msg_client == st.pk_client &&
                    it.msg_sequence == st.pk_seq && it.mask_or_field == st.pk_mask) begin
                    acc = 1'b1;
                    st.rep_int = it.payload[7:0];
                    st.rep_lvl = it.payload[15:8];
                    if (it.ack_status != STATUS_BUSY) begin
                        // drop carried dirty bits unless the setting changed meanwhile
                        for (int b = 0; b < 2; b++)
                            if (st.pk_mask[b] && st.rev[b] == st.snap[b])
                                st.dirty[b] = 1'b0;
                        st.pending   = 1'b0;
                        st.synced    = 1'b1;
                        st.last_sync = it.now;
                    end
                end
            end
            default: begin
            end
        endcase
        o.st              = st;
        o.r.send          = snd;
        o.r.tx_mac        = snd ? st.peer_addr : 48'd0;
        o.r.tx_session    = snd ? st.pk_session : 32'd0;
        o.r.tx_client     = snd ? st.pk_client : 32'd0;
        o.r.tx_sequence   = snd ? st.pk_seq : 32'd0;
        o.r.tx_mask       = snd ? st.pk_mask : 2'd0;
        o.r.tx_intensity  = snd ? st.pk_int : 7'd0;
        o.r.tx_level      = snd ? st.pk_lvl : 2'd0;
        o.r.rpt_intensity = st.rep_int;
        o.r.rpt_level     = st.rep_lvl;
        o.r.accepted      = acc;
        return o;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.cmd            = 2'($urandom_range(0, 3));
        it.now            = $urandom();
        it.link_live      = 1'($urandom_range(0, 1));
        it.tgt_mac        = rand48();
        it.tgt_session    = $urandom();
        it.peer_mac       = rand48();
        it.msg_session    = $urandom();
        it.msg_client     = $urandom();
        it.msg_sequence   = $urandom();
        it.mask_or_field  = 2'($urandom_range(0, 3));
        it.payload        = 16'($urandom());
        it.ack_status     = 2'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic in_item_t set_item(logic [1:0] field, logic [7:0] v);
        in_item_t it;
        it                 = rand_item();
        it.cmd             = CMD_SET;
        it.now             = tick;
        it.mask_or_field   = field;
        it.payload[7:0]    = v;
        return it;
    endfunction

    function automatic in_item_t poll_item(logic live, logic [31:0] client);
        in_item_t it;
        it                = rand_item();
        it.cmd            = CMD_POLL;
        it.now            = tick;
        it.link_live      = live;
        it.tgt_mac        = cur_mac;
        it.tgt_session    = cur_sess;
        it.msg_client     = client;
        return it;
    endfunction

    // acknowledgement that matches the transaction the plan has open
    function automatic in_item_t ack_item(logic [1:0] status);
        in_item_t it;
        it                = rand_item();
        it.cmd            = CMD_ACK;
        it.now            = tick;
        it.link_live      = 1'b1;
        it.tgt_mac        = cur_mac;
        it.tgt_session    = cur_sess;
        it.peer_mac       = cur_mac;
        it.msg_session    = plan_st.pk_session;
        it.msg_client     = plan_st.pk_client;
        it.msg_sequence   = plan_st.pk_seq;
        it.mask_or_field  = plan_st.pk_mask;
        it.ack_status     = status;
        return it;
    endfunction

    // queue a beat and advance the planning copy of the state
    task automatic push_item(in_item_t it);
        sync_step_t p;
        p = sync_step(plan_st, it);
        plan_st = p.st;
        beats_to_send.push_back(it);
    endtask

    task automatic random_item();
        in_item_t    it;
        int unsigned r;
        int unsigned s;
        logic [1:0]  f;
        logic [7:0]  v;
        logic [1:0]  status;
        s = $urandom_range(0, 99);
        if (s < 55)
            tick += $urandom_range(0, 20);
        else if (s < 85)
            tick += $urandom_range(0, 400);
        else if (s < 97)
            tick += $urandom_range(0, 2000);
        else
            tick += $urandom();
        r = $urandom_range(0, 99);
        if (r < 30) begin
            if ($urandom_range(0, 9) == 0)
                f = 2'($urandom_range(0, 3));
            else
                f = $urandom_range(0, 1) ? FIELD_INTENSITY : FIELD_LEVEL;
            if ($urandom_range(0, 6) == 0)
                v = 8'($urandom_range(0, 255));
            else if (f == FIELD_LEVEL)
                v = 8'($urandom_range(LEVEL_MIN, LEVEL_MAX));
            else
                v = 8'($urandom_range(0, INTENSITY_MAX));
            it = set_item(f, v);
        end else if (r < 62) begin
            // now and then a new target, same address or same session possibly
            if ($urandom_range(0, 19) == 0) begin
                cur_mac  = mac_pool[2'($urandom_range(0, 2))];
                cur_sess = sess_pool[2'($urandom_range(0, 2))];
            end
            it = poll_item($urandom_range(0, 15) != 0,
                           ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom());
        end else if (r < 95) begin
            s = $urandom_range(0, 9);
            if (s < 4)
                status = STATUS_APPLIED;
            else if (s < 6)
                status = STATUS_NOT_APPLIED;
            else if (s < 8)
                status = STATUS_BUSY;
            else
                status = STATUS_RESERVED;
            it = ack_item(status);
            // break one match condition
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 7))
                    0: it.peer_mac       = it.peer_mac ^ (48'd1 << $urandom_range(0, 47));
                    1: it.msg_session    = it.msg_session + 32'd1;
                    2: it.msg_client     = it.msg_client ^ (32'd1 << $urandom_range(0, 31));
                    3: it.msg_sequence   = it.msg_sequence - 32'd1;
                    4: begin
                        f = 2'($urandom_range(1, 3));
                        it.mask_or_field = it.mask_or_field ^ f;
                    end
                    5: it.link_live      = 1'b0;
                    6: it.tgt_session    = it.tgt_session + 32'd1;
                    default: it.tgt_mac  = it.tgt_mac ^ 48'd1;
                endcase
            end
        end else begin
            it = rand_item();
        end
        push_item(it);
    endtask

    task automatic random_phase(int unsigned n, bit pace);
        @(posedge aclk);
        tx_pace = pace;
        rx_pace = pace;
        repeat (n) random_item();
    endtask

    // everything sent, every result back, block drained
    task automatic wait_idle();
        while (beats_to_send.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_RETRY_INTERVAL) begin
            model_st.retry_ticks = val;
            plan_st.retry_ticks  = val;
        end else begin
            model_st.query_ticks = val;
            plan_st.query_ticks  = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // sender: next beat from the queue after a random gap
    always @(negedge aclk) begin
        if (!s_tvalid || s_taken) begin
            s_taken <= 1'b0;
            if (tx_wait != 0) begin
                tx_wait  <= tx_wait - 1;
                s_tvalid <= 1'b0;
            end else if (beats_to_send.size() != 0) begin
                s_cur = beats_to_send.pop_front();
                s_tdata <= {3'b000, s_cur.ack_status, s_cur.payload, s_cur.mask_or_field,
                            s_cur.msg_sequence, s_cur.msg_client, s_cur.msg_session,
                            s_cur.peer_mac, s_cur.tgt_session, s_cur.tgt_mac,
                            s_cur.link_live, s_cur.now};
                s_tuser  <= s_cur.cmd;
                s_tvalid <= 1'b1;
                tx_wait  <= tx_pace ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict each accepted input beat
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            model_step = sync_step(model_st, s_cur);
            model_st   = model_step.st;
            due_results.push_back(model_step.r);
            s_taken <= 1'b1;
        end
    end

    // two long hold-offs on the result side to back up the input
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && results_seen >= 60) ||
                     (holds_done == 1 && results_seen >= 330)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // receiver: random stalls, held off while a long hold-off runs
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_wait  <= rx_pace ? pick_gap() : 0;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            {m_pad, seen_r.accepted, seen_r.rpt_level, seen_r.rpt_intensity,
             seen_r.tx_level, seen_r.tx_intensity, seen_r.tx_mask, seen_r.tx_sequence,
             seen_r.tx_client, seen_r.tx_session, seen_r.tx_mac} = m_tdata;
            seen_r.send = m_tuser[0];
            results_seen <= results_seen + 1;
            if (due_results.size() == 0) begin
                $error("result beat arrived with no prediction waiting");
                errors++;
            end else begin
                due_r = due_results.pop_front();
                check_field("send", 64'(due_r.send), 64'(seen_r.send));
                check_field("tx_mac", 64'(due_r.tx_mac), 64'(seen_r.tx_mac));
                check_field("tx_session", 64'(due_r.tx_session), 64'(seen_r.tx_session));
                check_field("tx_client", 64'(due_r.tx_client), 64'(seen_r.tx_client));
                check_field("tx_sequence", 64'(due_r.tx_sequence), 64'(seen_r.tx_sequence));
                check_field("tx_mask", 64'(due_r.tx_mask), 64'(seen_r.tx_mask));
                check_field("tx_intensity", 64'(due_r.tx_intensity),
                            64'(seen_r.tx_intensity));
                check_field("tx_level", 64'(due_r.tx_level), 64'(seen_r.tx_level));
                check_field("rpt_intensity", 64'(due_r.rpt_intensity),
                            64'(seen_r.rpt_intensity));
                check_field("rpt_level", 64'(due_r.rpt_level), 64'(seen_r.rpt_level));
                check_field("accepted", 64'(due_r.accepted), 64'(seen_r.accepted));
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        in_item_t it;
        for (int k = 0; k < 3; k++) begin
            mac_pool[k]  = rand48();
            sess_pool[k] = $urandom();
        end
        cur_mac  = mac_pool[0];
        cur_sess = sess_pool[0];
        model_st = reset_state();
        plan_st  = reset_state();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset timing, time base about to wrap
        tx_pace = 1'b1;
        rx_pace = 1'b1;
        tick = 32'hFFFF_FFF0;
        push_item(poll_item(1'b0, $urandom()));
        push_item(set_item(FIELD_INTENSITY, 8'd0));
        push_item(set_item(FIELD_INTENSITY, INTENSITY_MAX));
        push_item(set_item(FIELD_INTENSITY, INTENSITY_MAX + 8'd1));
        push_item(set_item(FIELD_LEVEL, 8'd0));
        push_item(set_item(FIELD_LEVEL, LEVEL_MIN));
        push_item(set_item(FIELD_LEVEL, LEVEL_MAX));
        push_item(set_item(FIELD_LEVEL, LEVEL_MAX + 8'd1));
        push_item(set_item(FIELD_NONE, 8'd5));
        push_item(set_item(FIELD_BOTH, 8'd5));
        // first target, zero nonce word: query goes out
        push_item(poll_item(1'b1, 32'd0));
        tick += 10;
        push_item(ack_item(STATUS_BUSY));
        tick += 10;
        push_item(poll_item(1'b1, $urandom()));
        // retry interval passed, across the wrap
        tick += 250;
        push_item(poll_item(1'b1, $urandom()));
        push_item(ack_item(STATUS_APPLIED));
        tick += 1;
        push_item(poll_item(1'b1, $urandom()));
        // intensity changes while its transaction is open
        push_item(set_item(FIELD_INTENSITY, 8'd77));
        push_item(ack_item(STATUS_RESERVED));
        push_item(poll_item(1'b1, $urandom()));
        it = ack_item(STATUS_APPLIED);
        it.msg_sequence = it.msg_sequence + 32'd1;
        push_item(it);
        push_item(ack_item(STATUS_NOT_APPLIED));
        push_item(poll_item(1'b1, $urandom()));
        // query period passed
        tick += 1000;
        push_item(poll_item(1'b1, $urandom()));
        it = rand_item();
        it.cmd = CMD_RESERVED;
        push_item(it);
        cur_sess = sess_pool[1];
        push_item(poll_item(1'b1, $urandom()));
        push_item(poll_item(1'b0, $urandom()));

        // shortest timing
        wait_idle();
        write_reg(CFG_RETRY_INTERVAL, 32'd1);
        write_reg(CFG_QUERY_PERIOD, 32'd1);
        random_phase(140, 1'b1);

        // longest timing, no idling
        wait_idle();
        write_reg(CFG_RETRY_INTERVAL, 32'hFFFF_FFFF);
        write_reg(CFG_QUERY_PERIOD, 32'hFFFF_FFFF);
        random_phase(130, 1'b0);

        // random moderate timing
        wait_idle();
        write_reg(CFG_RETRY_INTERVAL, $urandom_range(1, 600));
        write_reg(CFG_QUERY_PERIOD, $urandom_range(1, 3000));
        random_phase(140, 1'b1);

        // back to reset timing
        wait_idle();
        write_reg(CFG_RETRY_INTERVAL, RETRY_INTERVAL_RESET);
        write_reg(CFG_QUERY_PERIOD, QUERY_PERIOD_RESET);
        random_phase(120, 1'b1);

        wait_idle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
